### rtl/core/kstir_pkg.sv
// ----------------------------------------------------------------------------
// kstir_pkg
// Shared constants, codes and types of the key set table.
// ----------------------------------------------------------------------------
package kstir_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_CHARS   = 7;

    localparam int KEY_W   = 8 * KEY_CHARS;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_FIELD_W = 56;
    localparam int STATUS_W    = 3;
    localparam int USED_W      = 8;
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   entries_used;
    } res_t;

endpackage

### rtl/core/key_set_table_insert_remove.sv
// ----------------------------------------------------------------------------
// key_set_table_insert_remove
// Table of distinct keys with insert and remove requests, one status per
// request.
//
//   channel  dir  handshake          tdata / tuser
//   s_       in   s_tvalid/s_tready  tdata: key[55:0]; tuser: req_type
//   m_       out  m_tvalid/m_tready  tdata: status[2:0], entries_used[10:3]
//
// An insert of a new key or a miss reads every entry in use; a search ends at
// the first hit, and a removal then shifts the later entries. The single RAM
// read port visits one entry a cycle.
// Reset clears the entry count and the control state; the key RAM needs no clearing pass.
// A new request is taken while the previous status waits in the output
// register; a stalled m_ side holds the sequencer only at the end of a request.
// ----------------------------------------------------------------------------
module key_set_table_insert_remove (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kstir_pkg::S_DATA_W-1:0]   s_tdata,   // key[55:0]
    input  logic                             s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kstir_pkg::M_DATA_W-1:0]   m_tdata    // status, entries_used
);
    import kstir_pkg::*;

    mem_req_t         mem_req;
    logic [KEY_W-1:0] mem_rdata;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             m_tvalid_reg, m_tvalid_next;
    res_t             m_res_reg, m_res_next;

    kstir_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    kstir_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (s_tuser),
        .req_key   (s_tdata[KEY_W-1:0]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            m_res_next    = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - USED_W){1'b0}},
                       m_res_reg.entries_used, m_res_reg.status};

    a_busy_while_reporting: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("request accepted while a status is pending");

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted back to back");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res_reg.status == ST_INSERTED) |-> (m_res_reg.entries_used != '0))
        else $error("inserted status with an empty table");

    a_full_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res_reg.status == ST_FULL)
            |-> (m_res_reg.entries_used == USED_W'(TABLE_DEPTH)))
        else $error("table full status with free entries");

endmodule

### rtl/core/kstir_ram.sv
// ----------------------------------------------------------------------------
// kstir_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kstir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/kstir_ctrl.sv
// ----------------------------------------------------------------------------
// kstir_ctrl
// Request sequencer: linear search, append on insert, shift-up on remove.
// ----------------------------------------------------------------------------
module kstir_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          req_type,
    input  logic [kstir_pkg::KEY_W-1:0]   req_key,
    output kstir_pkg::mem_req_t           mem_req,
    input  logic [kstir_pkg::KEY_W-1:0]   mem_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output kstir_pkg::res_t               res
);
    import kstir_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                type_reg, type_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rd_en;
    logic                hit;
    logic [CNT_W-1:0]    shift_dst;

    assign rd_en     = (rd_idx_reg < count_reg);
    assign hit       = cmp_vld_reg && (mem_rdata == key_reg);
    assign shift_dst = cmp_idx_reg - CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        type_next     = type_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = rd_idx_reg;
        status_next   = status_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[IDX_W-1:0];
        mem_req.wdata = key_reg;
        mem_req.raddr = rd_idx_reg[IDX_W-1:0];
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    type_next   = req_type;
                    key_next    = req_key;
                    rd_idx_next = '0;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmp_vld_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (hit) begin
                    cmp_vld_next = 1'b0;
                    if (type_reg == REQ_INSERT) begin
                        status_next = ST_PRESENT;
                        state_next  = S_DONE;
                    end else begin
                        rd_idx_next = cmp_idx_reg + CNT_W'(1);
                        state_next  = S_SHIFT;
                    end
                end else if (!rd_en && !cmp_vld_reg) begin
                    state_next = S_DONE;
                    if (type_reg == REQ_REMOVE) begin
                        status_next = ST_NOT_FOUND;
                    end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        mem_req.we  = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_INSERTED;
                    end
                end
            end
            S_SHIFT: begin
                // move each later entry up one place, one read and one write a cycle
                cmp_vld_next = rd_en;
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = shift_dst[IDX_W-1:0];
                    mem_req.wdata = mem_rdata;
                end
                if (!rd_en && !cmp_vld_reg) begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_REMOVED;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status       = status_reg;
    assign res.entries_used = USED_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg    <= type_next;
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
    end

endmodule
